// ----- rtl/core/pip_pkg.sv -----
// Shared constants for the point-in-polygon crossing-number block.
// No dependencies; imported by the top level.
package pip_pkg;

    // Polygon storage depth and derived widths
    localparam int MAX_VERTICES = 64;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 7;
    localparam int VERT_W  = 2 * COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TEST  = 1'b1;

endpackage

// ----- rtl/core/point_in_polygon_test_top.sv -----
// Point-in-polygon test, even-odd rule, vertices held in a pip_ram instance.
// A query with n vertices in use (n >= 1) is answered once its edge walk and
// pipeline have drained; with n = 0 it skips the walk. Next start is taken the cycle after.
// Throughput is set by the single read port: one edge per cycle, n+1 reads.
// Vertex writes are taken only while idle. Result strobe o_valid is one cycle wide.
// Reset (synchronous, active low) clears control and the vertex count only.
module point_in_polygon_test_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [pip_pkg::IDX_W-1:0]    i_vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0] i_coord_y,
    input  logic                         i_cfg_wen,
    input  logic [pip_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                         o_valid,
    output logic                         o_inside_res
);
    import pip_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]               r_state, n_state;
    logic [CFG_W-1:0]         r_vcount;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_inside;

    logic signed [COORD_W-1:0] r_qx, r_qy;
    logic signed [COORD_W-1:0] r_lx, r_ly;

    // Pipeline valids: read in flight, differences, products
    logic r_v1, r_first1, r_v2, r_v3;
    logic r_str2, r_str3, r_dyneg3;
    logic signed [DIFF_W-1:0] r_a, r_b, r_c, r_dy;
    logic signed [PROD_W-1:0] r_p, r_q;

    logic                 accept, wr_xfer, qry_xfer, ram_we, issue;
    logic [ADDR_W-1:0]    rd_addr;
    logic [VERT_W-1:0]    rdata;
    logic signed [COORD_W-1:0] cx, cy;
    logic                 straddle, ge;
    logic [CNT_W-1:0]     n_eff;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign wr_xfer  = accept && (i_opcode == OP_WRITE);
    assign qry_xfer = accept && (i_opcode == OP_TEST);
    assign ram_we   = wr_xfer && (32'(i_vertex_index) < MAX_VERTICES);

    // Clamp the vertex count to the store depth
    assign n_eff = (32'(r_vcount) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES) : CNT_W'(r_vcount);

    // First read fetches the last vertex, then vertices 0 .. n-1
    assign issue   = (r_state == S_RUN);
    assign rd_addr = (r_cnt == '0) ? ADDR_W'(r_n - 1'b1) : ADDR_W'(r_cnt - 1'b1);

    pip_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_vertex_index)),
        .i_wdata ({i_coord_y, i_coord_x}),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (qry_xfer) begin
                    n_n   = n_eff;
                    n_cnt = '0;
                    n_state = (n_eff == '0) ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vcount <= '0;
            r_n      <= '0;
            r_cnt    <= '0;
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_inside <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_cnt    <= n_cnt;
            if (i_cfg_wen) begin
                r_vcount <= i_cfg_wdata;
            end
            r_v1     <= issue;
            r_first1 <= issue && (r_cnt == '0);
            r_v2     <= r_v1 && !r_first1;
            r_v3     <= r_v2;
            // Toggle on a counted crossing; clear for a new query
            if (qry_xfer) begin
                r_inside <= 1'b0;
            end else if (r_v3 && r_str3 && ge) begin
                r_inside <= !r_inside;
            end
        end
    end

    // Edge stage: straddle test and differences against previous vertex
    assign cx = rdata[COORD_W-1:0];
    assign cy = rdata[VERT_W-1:COORD_W];
    assign straddle = (cy > r_qy) != (r_ly > r_qy);

    // Crossing compare: toggle iff a*dy >= b*c for dy > 0, a*dy <= b*c for dy < 0
    assign ge = r_dyneg3 ? (r_p <= r_q) : (r_p >= r_q);

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (qry_xfer) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
        end
        if (r_v1) begin
            r_lx <= cx;
            r_ly <= cy;
        end
        r_str2 <= straddle;
        r_a    <= DIFF_W'(r_qx) - DIFF_W'(cx);
        r_b    <= DIFF_W'(r_lx) - DIFF_W'(cx);
        r_c    <= DIFF_W'(r_qy) - DIFF_W'(cy);
        r_dy   <= DIFF_W'(r_ly) - DIFF_W'(cy);
        r_p      <= PROD_W'(r_a) * PROD_W'(r_dy);
        r_q      <= PROD_W'(r_b) * PROD_W'(r_c);
        r_str3   <= r_str2;
        r_dyneg3 <= r_dy[DIFF_W-1];
    end

    assign o_valid      = (r_state == S_DONE);
    assign o_inside_res = r_inside;

    // Checks
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("block still busy after result");

    a_no_write_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_IDLE))
        else $error("vertex write during query walk");

    a_pipe_only_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> (r_state == S_RUN || r_state == S_DRAIN))
        else $error("edge pipeline active outside walk");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt <= r_n && r_n != '0))
        else $error("read counter out of range");

endmodule

// ----- rtl/core/pip_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pip_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
